// ===== hw/rtl/accu_pkg.sv =====
// shared types and constants of the undo-history accumulator
package accu_pkg;

	localparam int DATA_W   = 32;
	localparam int KIND_W   = 3;
	localparam int STATUS_W = 3;
	localparam int COUNT_W  = 7;

	localparam logic signed [DATA_W-1:0] Q_MAX = {1'b0, {(DATA_W-1){1'b1}}};
	localparam logic signed [DATA_W-1:0] Q_MIN = {1'b1, {(DATA_W-1){1'b0}}};

	typedef enum logic [KIND_W-1:0] {
		KIND_ADD  = 3'd0,
		KIND_SUB  = 3'd1,
		KIND_MUL  = 3'd2,
		KIND_DIV  = 3'd3,
		KIND_UNDO = 3'd4
	} accu_kind_t;

	typedef enum logic [STATUS_W-1:0] {
		STAT_OK         = 3'd0,
		STAT_DIV_ZERO   = 3'd1,
		STAT_UNDO_EMPTY = 3'd2,
		STAT_FULL       = 3'd3,
		STAT_SAT        = 3'd4
	} accu_status_t;

	typedef struct packed {
		logic                     done;
		logic                     sat;
		logic signed [DATA_W-1:0] quot;
	} accu_div_res_t;

endpackage

// ===== hw/rtl/accu_ifs.sv =====
// command and result channel interfaces
interface accu_cmd_if import accu_pkg::*; ();
	logic                     valid;
	logic                     ready;
	logic [KIND_W-1:0]        kind;
	logic signed [DATA_W-1:0] operand;

	modport source(output valid, kind, operand, input ready);
	modport sink(input valid, kind, operand, output ready);
endinterface

interface accu_res_if import accu_pkg::*; ();
	logic                     valid;
	logic                     ready;
	logic signed [DATA_W-1:0] total;
	logic [COUNT_W-1:0]       entry_count;
	logic [STATUS_W-1:0]      status;

	modport source(output valid, total, entry_count, status, input ready);
	modport sink(input valid, total, entry_count, status, output ready);
endinterface

// ===== hw/rtl/accu_history.sv =====
// history stack storage: one write port, one registered read port
module accu_history #(
	parameter int DEPTH = 64,
	localparam int ADDR_W = $clog2(DEPTH)
) (
	input  logic              clk,
	input  logic              wr_en,
	input  logic [ADDR_W-1:0] wr_addr,
	input  logic [31:0]       wr_data,
	input  logic              rd_en,
	input  logic [ADDR_W-1:0] rd_addr,
	output logic [31:0]       rd_data
);

	logic [31:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule

// ===== hw/rtl/accu_divider.sv =====
// radix-2 restoring divider for (a * 2^16) / b with truncation and saturation
module accu_divider import accu_pkg::*; (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     start,
	input  logic signed [DATA_W-1:0] dividend,
	input  logic signed [DATA_W-1:0] divisor,
	output accu_div_res_t            res
);

	localparam int FRAC_W    = 16;
	localparam int DIV_STEPS = DATA_W + FRAC_W;
	localparam int STEP_W    = $clog2(DIV_STEPS);

	localparam logic [DIV_STEPS-1:0] NEG_LIMIT = DIV_STEPS'(1) << (DATA_W - 1);
	localparam logic [DIV_STEPS-1:0] POS_LIMIT = NEG_LIMIT - DIV_STEPS'(1);

	logic                 busy_q;
	logic                 fin_q;
	logic                 done_q;
	logic [STEP_W-1:0]    step_q;
	logic [DATA_W-1:0]    rem_q;
	logic [DIV_STEPS-1:0] quo_q;
	logic [DATA_W-1:0]    dvs_q;
	logic                 neg_q;
	logic                 sat_q;
	logic [DATA_W-1:0]    quot_q;

	logic [DATA_W-1:0]    dvd_mag;
	logic [DATA_W-1:0]    dvs_mag;
	logic [DATA_W:0]      rem_sh;
	logic                 take;
	logic [DATA_W:0]      rem_diff;

	assign dvd_mag  = dividend[DATA_W-1] ? DATA_W'(-dividend) : DATA_W'(dividend);
	assign dvs_mag  = divisor[DATA_W-1] ? DATA_W'(-divisor) : DATA_W'(divisor);
	assign rem_sh   = {rem_q, quo_q[DIV_STEPS-1]};
	assign take     = rem_sh >= {1'b0, dvs_q};
	assign rem_diff = rem_sh - {1'b0, dvs_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			fin_q  <= 1'b0;
			done_q <= 1'b0;
			step_q <= '0;
		end else begin
			done_q <= fin_q;
			fin_q  <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				step_q <= '0;
			end else if (busy_q) begin
				step_q <= step_q + STEP_W'(1);
				if (step_q == STEP_W'(DIV_STEPS - 1)) begin
					busy_q <= 1'b0;
					fin_q  <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= {dvd_mag, {FRAC_W{1'b0}}};
			rem_q <= '0;
			dvs_q <= dvs_mag;
			neg_q <= dividend[DATA_W-1] ^ divisor[DATA_W-1];
		end else if (busy_q) begin
			// quotient bits shift in from the bottom as dividend bits leave the top
			quo_q <= {quo_q[DIV_STEPS-2:0], take};
			rem_q <= take ? rem_diff[DATA_W-1:0] : rem_sh[DATA_W-1:0];
		end
		if (fin_q) begin
			if (neg_q) begin
				sat_q  <= quo_q > NEG_LIMIT;
				quot_q <= (quo_q > NEG_LIMIT) ? Q_MIN : DATA_W'(-quo_q[DATA_W-1:0]);
			end else begin
				sat_q  <= quo_q > POS_LIMIT;
				quot_q <= (quo_q > POS_LIMIT) ? Q_MAX : quo_q[DATA_W-1:0];
			end
		end
	end

	assign res.done = done_q;
	assign res.sat  = sat_q;
	assign res.quot = quot_q;

endmodule

// ===== hw/rtl/accumulator_with_undo_history_top.sv =====
// Signed Q16.16 running-total calculator with an undo history of HISTORY_DEPTH
// totals held in a single-port-write, registered-read memory. One command is
// worked on at a time: add, subtract, rejected commands and unused kinds pass
// S_EXEC and S_FIN before the result register, multiply S_EXEC, S_MUL (product
// register) and S_FIN, undo S_EXEC, S_UNDO (registered history read) and S_FIN,
// divide S_EXEC, S_DIV (held by the 48-step radix-2 divider) and S_FIN. The next
// command is taken in the cycle after the result is loaded, even while that
// result waits on res.ready. History memory contents are never cleared; only
// entries below the count are used, so no clearing pass runs after reset.
module accumulator_with_undo_history_top import accu_pkg::*; #(
	parameter int HISTORY_DEPTH = 64
) (
	input  logic       clk,
	input  logic       arst_n,
	accu_cmd_if.sink   cmd,
	accu_res_if.source res
);

	localparam int CNT_W  = $clog2(HISTORY_DEPTH + 1);
	localparam int ADDR_W = $clog2(HISTORY_DEPTH);
	localparam int EXT_W  = (CNT_W > COUNT_W) ? CNT_W : COUNT_W;

	typedef enum logic [5:0] {
		S_IDLE = 6'b000001,
		S_EXEC = 6'b000010,
		S_MUL  = 6'b000100,
		S_DIV  = 6'b001000,
		S_UNDO = 6'b010000,
		S_FIN  = 6'b100000
	} state_t;

	typedef enum logic [1:0] {
		HOP_NONE = 2'd0,
		HOP_PUSH = 2'd1,
		HOP_POP  = 2'd2
	} hist_op_t;

	state_t                   state_q;
	logic [KIND_W-1:0]        kind_s1;
	logic signed [DATA_W-1:0] operand_s1;
	logic signed [63:0]       prod_s2;
	logic signed [DATA_W-1:0] total_q;
	logic [CNT_W-1:0]         count_q;
	logic signed [DATA_W-1:0] res_total_q;
	accu_status_t             res_status_q;
	hist_op_t                 res_op_q;
	logic                     out_valid_q;
	logic signed [DATA_W-1:0] out_total_q;
	logic [COUNT_W-1:0]       out_count_q;
	logic [STATUS_W-1:0]      out_status_q;

	logic                     fin_go;
	logic                     hist_full;
	logic [CNT_W-1:0]         cnt_next;
	logic [CNT_W-1:0]         cnt_m2;
	logic [EXT_W-1:0]         cnt_ext;
	logic signed [DATA_W:0]   sum;
	logic                     sum_sat;
	logic signed [DATA_W-1:0] sum_val;
	logic signed [63:0]       prod;
	logic signed [63:0]       prod_adj;
	logic signed [63:0]       prod_shr;
	logic                     mul_sat;
	logic signed [DATA_W-1:0] mul_val;
	logic                     div_start;
	accu_div_res_t            div_res;
	logic                     hist_rd_en;
	logic [DATA_W-1:0]        hist_rd_data;

	assign fin_go    = (state_q == S_FIN) && (!out_valid_q || res.ready);
	assign hist_full = count_q == CNT_W'(HISTORY_DEPTH);
	assign cnt_m2    = count_q - CNT_W'(2);

	always_comb begin
		unique case (res_op_q)
			HOP_PUSH: cnt_next = count_q + CNT_W'(1);
			HOP_POP:  cnt_next = count_q - CNT_W'(1);
			default:  cnt_next = count_q;
		endcase
	end
	assign cnt_ext = EXT_W'(cnt_next);

	// add and subtract with one guard bit
	assign sum     = (kind_s1 == KIND_SUB)
		? ({total_q[DATA_W-1], total_q} - {operand_s1[DATA_W-1], operand_s1})
		: ({total_q[DATA_W-1], total_q} + {operand_s1[DATA_W-1], operand_s1});
	assign sum_sat = sum[DATA_W] != sum[DATA_W-1];
	assign sum_val = sum_sat ? (sum[DATA_W] ? Q_MIN : Q_MAX) : sum[DATA_W-1:0];

	// multiply: product registered, then truncate toward zero and clamp
	assign prod     = total_q * operand_s1;
	assign prod_adj = prod_s2 + (prod_s2[63] ? 64'sd65535 : 64'sd0);
	assign prod_shr = prod_adj >>> 16;
	assign mul_sat  = !((&prod_shr[63:DATA_W-1]) || !(|prod_shr[63:DATA_W-1]));
	assign mul_val  = mul_sat ? (prod_shr[63] ? Q_MIN : Q_MAX) : prod_shr[DATA_W-1:0];

	assign div_start  = (state_q == S_EXEC) && (kind_s1 == KIND_DIV)
		&& (operand_s1 != '0) && !hist_full;
	// entry below the top; its data is only used when the history keeps at least one
	assign hist_rd_en = (state_q == S_EXEC) && (kind_s1 == KIND_UNDO);

	accu_divider u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (total_q),
		.divisor  (operand_s1),
		.res      (div_res)
	);

	accu_history #(
		.DEPTH (HISTORY_DEPTH)
	) u_hist (
		.clk     (clk),
		.wr_en   (fin_go && (res_op_q == HOP_PUSH)),
		.wr_addr (count_q[ADDR_W-1:0]),
		.wr_data (res_total_q),
		.rd_en   (hist_rd_en),
		.rd_addr (cnt_m2[ADDR_W-1:0]),
		.rd_data (hist_rd_data)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			total_q     <= '0;
			count_q     <= '0;
			out_valid_q <= 1'b0;
			res_op_q    <= HOP_NONE;
		end else begin
			if (res.ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (cmd.valid) begin
						state_q <= S_EXEC;
					end
				end
				S_EXEC: begin
					res_op_q <= HOP_NONE;
					state_q  <= S_FIN;
					if (kind_s1 <= KIND_DIV) begin
						if ((kind_s1 == KIND_DIV) && (operand_s1 == '0)) begin
							state_q <= S_FIN;
						end else if (hist_full) begin
							state_q <= S_FIN;
						end else if (kind_s1 == KIND_MUL) begin
							state_q <= S_MUL;
						end else if (kind_s1 == KIND_DIV) begin
							state_q <= S_DIV;
						end else begin
							res_op_q <= HOP_PUSH;
						end
					end else if (kind_s1 == KIND_UNDO) begin
						if (count_q != '0) begin
							res_op_q <= HOP_POP;
							state_q  <= S_UNDO;
						end
					end
				end
				S_MUL: begin
					res_op_q <= HOP_PUSH;
					state_q  <= S_FIN;
				end
				S_DIV: begin
					if (div_res.done) begin
						res_op_q <= HOP_PUSH;
						state_q  <= S_FIN;
					end
				end
				S_UNDO: begin
					state_q <= S_FIN;
				end
				S_FIN: begin
					if (fin_go) begin
						out_valid_q <= 1'b1;
						count_q     <= cnt_next;
						if (res_op_q != HOP_NONE) begin
							total_q <= res_total_q;
						end
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if ((state_q == S_IDLE) && cmd.valid) begin
			kind_s1    <= cmd.kind;
			operand_s1 <= cmd.operand;
		end
		if (state_q == S_EXEC) begin
			prod_s2      <= prod;
			res_total_q  <= total_q;
			res_status_q <= STAT_OK;
			if (kind_s1 <= KIND_DIV) begin
				if ((kind_s1 == KIND_DIV) && (operand_s1 == '0)) begin
					res_status_q <= STAT_DIV_ZERO;
				end else if (hist_full) begin
					res_status_q <= STAT_FULL;
				end else if ((kind_s1 == KIND_ADD) || (kind_s1 == KIND_SUB)) begin
					res_total_q  <= sum_val;
					res_status_q <= sum_sat ? STAT_SAT : STAT_OK;
				end
			end else if ((kind_s1 == KIND_UNDO) && (count_q == '0)) begin
				res_status_q <= STAT_UNDO_EMPTY;
			end
		end
		if (state_q == S_MUL) begin
			res_total_q  <= mul_val;
			res_status_q <= mul_sat ? STAT_SAT : STAT_OK;
		end
		if ((state_q == S_DIV) && div_res.done) begin
			res_total_q  <= div_res.quot;
			res_status_q <= div_res.sat ? STAT_SAT : STAT_OK;
		end
		if (state_q == S_UNDO) begin
			res_total_q <= (count_q == CNT_W'(1)) ? '0 : hist_rd_data;
		end
		if (fin_go) begin
			out_total_q  <= res_total_q;
			out_count_q  <= cnt_ext[COUNT_W-1:0];
			out_status_q <= res_status_q;
		end
	end

	assign cmd.ready       = state_q == S_IDLE;
	assign res.valid       = out_valid_q;
	assign res.total       = out_total_q;
	assign res.entry_count = out_count_q;
	assign res.status      = out_status_q;

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(HISTORY_DEPTH))
		else $error("history count beyond depth");

	a_reject_keeps_count: assert property (@(posedge clk) disable iff (!arst_n)
		(fin_go && (res_status_q == STAT_FULL || res_status_q == STAT_DIV_ZERO
			|| res_status_q == STAT_UNDO_EMPTY)) |=> $stable(count_q))
		else $error("rejected command changed the history count");

	a_div_done_in_div: assert property (@(posedge clk) disable iff (!arst_n)
		div_res.done |-> state_q == S_DIV)
		else $error("divider finished outside a divide");

	a_result_loaded: assert property (@(posedge clk) disable iff (!arst_n)
		fin_go |=> out_valid_q && state_q == S_IDLE)
		else $error("finished command did not reach the result register");

endmodule
